// ===== design/bpcp_pkg.sv =====
`timescale 1ns / 1ps

package bpcp_pkg;

  localparam int TERM_COUNT = 23;
  localparam int COEF_W     = 24;
  localparam int POW_W      = 40;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [7:0] REG_TORQUE_MEAN    = 8'd0;
  localparam logic [7:0] REG_TORQUE_INV_STD = 8'd1;
  localparam logic [7:0] REG_SPEED_MEAN     = 8'd2;
  localparam logic [7:0] REG_SPEED_INV_STD  = 8'd3;

  localparam logic [23:0] TORQUE_MEAN_RST    = 24'd18595;
  localparam logic [23:0] TORQUE_INV_STD_RST = 24'd394525;
  localparam logic [23:0] SPEED_MEAN_RST     = 24'd120260;
  localparam logic [23:0] SPEED_INV_STD_RST  = 24'd55901;

  typedef struct packed {
    logic signed [15:0] torque;
    logic signed [15:0] speed;
  } sample_t;

  typedef struct packed {
    logic signed [47:0] dc_current;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic signed [23:0] torque_mean;
    logic        [23:0] torque_inv_std;
    logic signed [23:0] speed_mean;
    logic        [23:0] speed_inv_std;
  } cfg_regs_t;

  // Normalised word handed from the front to the back
  typedef struct packed {
    logic signed [15:0] xn;
    logic signed [15:0] yn;
    logic               clip;
    logic               degen;
  } norm_t;

  // Trained coefficients, Q8.16; all fit in 24 signed bits
  localparam logic signed [COEF_W-1:0] COEF [TERM_COUNT] = '{
    24'sd5892221, 24'sd3547670, 24'sd3555675, 24'sd231321, -24'sd91287,
    24'sd2050208, -24'sd19678, 24'sd95234, 24'sd125418, 24'sd145708,
    -24'sd6956, 24'sd171629, 24'sd12451, 24'sd75939, 24'sd114175,
    24'sd16763, 24'sd12542, -24'sd8705, -24'sd3950, 24'sd29505,
    24'sd982, -24'sd4340, -24'sd32913
  };

  localparam int EXP_X [TERM_COUNT] = '{
    0, 1, 0, 2, 0, 1, 3, 0, 2, 1, 4, 0, 3, 2, 1, 5, 0, 4, 3, 2, 1, 6, 0
  };
  localparam int EXP_Y [TERM_COUNT] = '{
    0, 0, 1, 0, 2, 1, 0, 3, 1, 2, 0, 4, 1, 2, 3, 0, 5, 1, 2, 3, 4, 0, 6
  };

endpackage

// ===== design/bpcp_front.sv =====
`timescale 1ns / 1ps

module bpcp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  bpcp_pkg::sample_t   sample,
  input  bpcp_pkg::cfg_regs_t regs,
  output logic                push,
  output bpcp_pkg::norm_t     entry
);

  logic               v1, v2;
  logic signed [24:0] diff_x, diff_y;
  logic signed [49:0] prod_x, prod_y;
  logic               degen1, degen2;
  logic signed [49:0] rnd_x, rnd_y;
  logic signed [15:0] n_x, n_y;
  logic               clip_x, clip_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      push <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      push <= v2;
    end
  end

  // diff = sample * 256 - mean, then times the reciprocal std
  always_ff @(posedge clk) begin
    diff_x <= {sample.torque[15], sample.torque, 8'h00} -
              {regs.torque_mean[23], regs.torque_mean};
    diff_y <= {sample.speed[15], sample.speed, 8'h00} -
              {regs.speed_mean[23], regs.speed_mean};
    degen1 <= (regs.torque_inv_std == '0) || (regs.speed_inv_std == '0);
    prod_x <= diff_x * $signed({1'b0, regs.torque_inv_std});
    prod_y <= diff_y * $signed({1'b0, regs.speed_inv_std});
    degen2 <= degen1;
  end

  // round half up to Q4.12 and clamp
  always_comb begin
    rnd_x  = (prod_x + 50'sd524288) >>> 20;
    rnd_y  = (prod_y + 50'sd524288) >>> 20;
    clip_x = 1'b0;
    clip_y = 1'b0;
    n_x    = rnd_x[15:0];
    n_y    = rnd_y[15:0];
    if (rnd_x > 50'sd32767) begin
      n_x = 16'sh7fff; clip_x = 1'b1;
    end else if (rnd_x < -50'sd32768) begin
      n_x = 16'sh8000; clip_x = 1'b1;
    end
    if (rnd_y > 50'sd32767) begin
      n_y = 16'sh7fff; clip_y = 1'b1;
    end else if (rnd_y < -50'sd32768) begin
      n_y = 16'sh8000; clip_y = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    entry.xn    <= n_x;
    entry.yn    <= n_y;
    entry.clip  <= clip_x | clip_y;
    entry.degen <= degen2;
  end

endmodule

// ===== design/bpcp_queue.sv =====
`timescale 1ns / 1ps

module bpcp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bpcp_pkg::norm_t wdata,
  input  logic            pop,
  output bpcp_pkg::norm_t rdata,
  output logic            empty,
  output logic            full
);

  bpcp_pkg::norm_t store [bpcp_pkg::QUEUE_DEPTH];
  logic [$clog2(bpcp_pkg::QUEUE_DEPTH)-1:0] wptr, rptr;
  logic [$clog2(bpcp_pkg::QUEUE_DEPTH):0]   count;
  logic do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign empty   = (count == '0);
  assign full    = (count == ($clog2(bpcp_pkg::QUEUE_DEPTH)+1)'(bpcp_pkg::QUEUE_DEPTH));
  assign rdata   = store[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      count <= count + (($clog2(bpcp_pkg::QUEUE_DEPTH)+1)'(do_push))
                     - (($clog2(bpcp_pkg::QUEUE_DEPTH)+1)'(do_pop));
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) store[wptr] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("word pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("word popped from empty queue");

endmodule

// ===== design/bpcp_back.sv =====
`timescale 1ns / 1ps

module bpcp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  bpcp_pkg::norm_t   entry,
  output logic              done,
  output bpcp_pkg::result_t result
);

  localparam int T     = bpcp_pkg::TERM_COUNT;
  localparam int PW    = bpcp_pkg::POW_W;
  localparam int LEVELS = $clog2(T);
  localparam int LAST  = 7 + LEVELS;

  logic [LAST:0] vld, clp, dgn;

  logic signed [15:0]   nx [0:5], ny [0:5];
  logic signed [PW-1:0] px [0:5][1:6];
  logic signed [PW-1:0] py [0:5][1:6];
  logic signed [PW-1:0] mono [T];
  logic signed [63:0]   tree [0:LEVELS][T];
  logic signed [63:0]   acc_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    clp <= {clp[LAST-1:0], entry.clip};
    dgn <= {dgn[LAST-1:0], entry.degen};
  end

  // first power: P1 = n * 256 in Q.20
  always_ff @(posedge clk) begin
    nx[0]    <= entry.xn;
    ny[0]    <= entry.yn;
    px[0][1] <= {{(PW-24){entry.xn[15]}}, entry.xn, 8'h00};
    py[0][1] <= {{(PW-24){entry.yn[15]}}, entry.yn, 8'h00};
  end

  // one power per stage: P(j+1) = round(Pj * n / 2^12)
  for (genvar j = 1; j <= 5; j++) begin : g_pow
    localparam int WK = 3 * j + 22;
    logic signed [WK+15:0] mx, my;
    assign mx = $signed(px[j-1][j][WK-1:0]) * nx[j-1];
    assign my = $signed(py[j-1][j][WK-1:0]) * ny[j-1];
    always_ff @(posedge clk) begin
      nx[j] <= nx[j-1];
      ny[j] <= ny[j-1];
      for (int k = 1; k <= j; k++) begin
        px[j][k] <= px[j-1][k];
        py[j][k] <= py[j-1][k];
      end
      px[j][j+1] <= PW'((mx + $signed({{(WK+4){1'b0}}, 1'b1, 11'b0})) >>> 12);
      py[j][j+1] <= PW'((my + $signed({{(WK+4){1'b0}}, 1'b1, 11'b0})) >>> 12);
    end
  end

  // monomials and coefficient products
  for (genvar t = 0; t < T; t++) begin : g_term
    localparam int A  = bpcp_pkg::EXP_X[t];
    localparam int B  = bpcp_pkg::EXP_Y[t];
    if (A == 0 && B == 0) begin : g_one
      always_ff @(posedge clk) mono[t] <= PW'(1048576);
    end else if (B == 0) begin : g_x
      always_ff @(posedge clk) mono[t] <= px[5][A];
    end else if (A == 0) begin : g_y
      always_ff @(posedge clk) mono[t] <= py[5][B];
    end else begin : g_xy
      localparam int WA = 3 * A + 22;
      localparam int WB = 3 * B + 22;
      logic signed [WA+WB-1:0] mp;
      assign mp = $signed(px[5][A][WA-1:0]) * $signed(py[5][B][WB-1:0]);
      always_ff @(posedge clk) begin
        mono[t] <= PW'((mp + $signed({{(WA+WB-20){1'b0}}, 1'b1, 19'b0})) >>> 20);
      end
    end
    always_ff @(posedge clk) begin
      tree[0][t] <= 64'(bpcp_pkg::COEF[t]) * 64'(mono[t]);
    end
  end

  // registered adder tree, an odd leftover passes up unchanged
  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int NP = (T + (1 << (l - 1)) - 1) >> (l - 1);
    localparam int NC = (NP + 1) / 2;
    for (genvar i = 0; i < NC; i++) begin : g_node
      if (2 * i + 1 < NP) begin : g_add
        always_ff @(posedge clk) tree[l][i] <= tree[l-1][2*i] + tree[l-1][2*i+1];
      end else begin : g_pass
        always_ff @(posedge clk) tree[l][i] <= tree[l-1][2*i];
      end
    end
  end

  // Q.36 to Q.16; the sum always fits 48 bits after the shift
  assign acc_rnd = (tree[LEVELS][0] + 64'sd524288) >>> 20;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (dgn[LAST]) begin
      result.dc_current <= '0;
      result.saturated  <= 1'b0;
    end else begin
      result.dc_current <= 48'(acc_rnd);
      result.saturated  <= clp[LAST];
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
      (vld[LAST] && dgn[LAST]) |=> (done && result.dc_current == '0 && !result.saturated))
    else $error("degenerate word did not give zero");

endmodule

// ===== design/bivariate_polynomial_current_predictor.sv =====
`timescale 1ns / 1ps
// Throughput: one sample pair per cycle; the product pipeline in the back end never stalls.
// busy only rises if the front-to-back queue fills, which a non-stalling back end prevents.
// Reset (rst, synchronous): clears all valid state and loads the default normalisation
// registers; the coefficient table is constant. Results cannot be held off by the receiver.
module bivariate_polynomial_current_predictor (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bpcp_pkg::sample_t sample,
  output logic              done,
  output bpcp_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [23:0]       cfg_data
);

  bpcp_pkg::cfg_regs_t regs;
  bpcp_pkg::norm_t     push_word, head_word;
  logic                accept, push, q_empty, q_full, pop;

  // Configuration words are taken every cycle; unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.torque_mean    <= bpcp_pkg::TORQUE_MEAN_RST;
      regs.torque_inv_std <= bpcp_pkg::TORQUE_INV_STD_RST;
      regs.speed_mean     <= bpcp_pkg::SPEED_MEAN_RST;
      regs.speed_inv_std  <= bpcp_pkg::SPEED_INV_STD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpcp_pkg::REG_TORQUE_MEAN:    regs.torque_mean    <= cfg_data;
        bpcp_pkg::REG_TORQUE_INV_STD: regs.torque_inv_std <= cfg_data;
        bpcp_pkg::REG_SPEED_MEAN:     regs.speed_mean     <= cfg_data;
        bpcp_pkg::REG_SPEED_INV_STD:  regs.speed_inv_std  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off new words only when the queue has no room.
  assign busy   = q_full;
  assign accept = start && !busy;

  // Front end: subtract the mean, scale, round and clamp to Q4.12.
  bpcp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (sample),
    .regs   (regs),
    .push   (push),
    .entry  (push_word)
  );

  // Short queue decouples the normaliser from the evaluator.
  bpcp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_word),
    .pop   (pop),
    .rdata (head_word),
    .empty (q_empty),
    .full  (q_full)
  );

  // Back end always drains the queue: advance one word per cycle.
  assign pop = !q_empty;

  bpcp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop),
    .entry    (head_word),
    .done     (done),
    .result   (result)
  );

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("queue filled although the back end never stalls");

endmodule

// ===== test/bpcp_checker.sv =====
`timescale 1ns / 1ps
module bpcp_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  bpcp_pkg::sample_t sample,
  input  logic              done,
  input  bpcp_pkg::result_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [23:0]       cfg_data,
  output int                fail_count,
  output int                pending
);

  bpcp_pkg::cfg_regs_t regs;
  bpcp_pkg::result_t   current_queue[$];

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint norm_val(logic signed [15:0] s, logic signed [23:0] mean,
                                      logic [23:0] inv, ref bit clip);
    longint d, n;
    d = longint'(s) * 256 - longint'(mean);
    n = round_sh(d * longint'({1'b0, inv}), 20);
    if (n > 32767) begin
      clip = 1;
      n = 32767;
    end else if (n < -32768) begin
      clip = 1;
      n = -32768;
    end
    return n;
  endfunction

  function automatic bpcp_pkg::result_t predict_current(bpcp_pkg::sample_t s,
                                                        bpcp_pkg::cfg_regs_t c);
    bpcp_pkg::result_t r;
    bit clip;
    longint xn, yn, acc, res;
    longint px[7], py[7];
    r = '0;
    clip = 0;
    acc = 0;
    if (c.torque_inv_std == 0 || c.speed_inv_std == 0) return r;
    xn = norm_val(s.torque, c.torque_mean, c.torque_inv_std, clip);
    yn = norm_val(s.speed, c.speed_mean, c.speed_inv_std, clip);
    px[0] = longint'(1) << 20;
    py[0] = longint'(1) << 20;
    for (int k = 0; k < 6; k++) begin
      px[k + 1] = round_sh(px[k] * xn, 12);
      py[k + 1] = round_sh(py[k] * yn, 12);
    end
    for (int t = 0; t < bpcp_pkg::TERM_COUNT; t++)
      acc += longint'(bpcp_pkg::COEF[t]) *
             round_sh(px[bpcp_pkg::EXP_X[t]] * py[bpcp_pkg::EXP_Y[t]], 20);
    res = round_sh(acc, 20);
    if (res > 64'sd140737488355327) begin
      res = 64'sd140737488355327;
      clip = 1;
    end else if (res < -64'sd140737488355328) begin
      res = -64'sd140737488355328;
      clip = 1;
    end
    r.dc_current = res[47:0];
    r.saturated = clip;
    return r;
  endfunction

  always @(posedge clk) begin
    bpcp_pkg::result_t want;
    if (rst) begin
      regs <= {bpcp_pkg::TORQUE_MEAN_RST, bpcp_pkg::TORQUE_INV_STD_RST,
               bpcp_pkg::SPEED_MEAN_RST, bpcp_pkg::SPEED_INV_STD_RST};
      fail_count <= 0;
      current_queue.delete();
    end else begin
      if (start && !busy) current_queue.push_back(predict_current(sample, regs));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bpcp_pkg::REG_TORQUE_MEAN:    regs.torque_mean    <= cfg_data;
          bpcp_pkg::REG_TORQUE_INV_STD: regs.torque_inv_std <= cfg_data;
          bpcp_pkg::REG_SPEED_MEAN:     regs.speed_mean     <= cfg_data;
          bpcp_pkg::REG_SPEED_INV_STD:  regs.speed_inv_std  <= cfg_data;
          default: ;
        endcase
      end
      if (done) begin
        if (current_queue.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, result);
          fail_count <= fail_count + 1;
        end else begin
          want = current_queue.pop_front();
          if (want.dc_current !== result.dc_current ||
              want.saturated !== result.saturated) begin
            $display("%0t: mismatch expected %0d/%0b actual %0d/%0b", $time,
                     want.dc_current, want.saturated,
                     result.dc_current, result.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= current_queue.size();
  end
endmodule

// ===== test/bivariate_polynomial_current_predictor_tb.sv =====
`timescale 1ns / 1ps
module bivariate_polynomial_current_predictor_tb;

  localparam int LATENCY = 17;
  localparam int STALL_LIMIT = 2000;

  logic              clk, rst, start, busy, done, cfg_valid, cfg_ready;
  bpcp_pkg::sample_t sample;
  bpcp_pkg::result_t result;
  logic [7:0]        cfg_index;
  logic [23:0]       cfg_data;
  int                fail_count, pending, idle_pct, quiet;

  bivariate_polynomial_current_predictor DUT (.*);

  bpcp_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Watchdog: count cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("bivariate_polynomial_current_predictor_tb: done, errors");
      $finish;
    end
  end

  // Offer one sample; hold it until taken. start is left high on return; the
  // next call's idle wait, write_reg or the end of the run drops it.
  task automatic send_sample(logic [15:0] t, logic [15:0] s);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    sample <= {t, s};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Registers move only when the pipe has drained.
  task automatic write_reg(logic [7:0] idx, logic [23:0] val);
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_all(logic [23:0] tm, logic [23:0] ti, logic [23:0] sm, logic [23:0] si);
    write_reg(bpcp_pkg::REG_TORQUE_MEAN, tm);
    write_reg(bpcp_pkg::REG_TORQUE_INV_STD, ti);
    write_reg(bpcp_pkg::REG_SPEED_MEAN, sm);
    write_reg(bpcp_pkg::REG_SPEED_INV_STD, si);
  endtask

  // Mostly small spread round the mean, sometimes anything at all.
  task automatic random_run(int n);
    logic [15:0] t, s;
    for (int i = 0; i < n; i++) begin
      t = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1000) - 500);
      s = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000) + 100);
      send_sample(t, s);
    end
  endtask

  initial begin
    logic [15:0] edges[5];
    edges = '{16'h8000, 16'hffff, 16'h0000, 16'h0001, 16'h7fff};
    rst = 1;
    start = 0;
    sample = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 0;

    // Directed: field extremes in every pairing, under reset registers.
    foreach (edges[i]) foreach (edges[j]) send_sample(edges[i], edges[j]);
    send_sample(16'd72, 16'd470);
    // Degenerate std on each side, then two ignored out-of-range indexes.
    write_reg(bpcp_pkg::REG_TORQUE_INV_STD, 24'd0);
    send_sample(16'd100, 16'd100);
    set_all(24'd18595, 24'd394525, 24'd120260, 24'd0);
    send_sample(16'd100, 16'd100);
    write_reg(8'd4, 24'hffffff);
    write_reg(8'hff, 24'h000000);
    set_all(24'd18595, 24'd394525, 24'd120260, 24'd55901);

    // Random phases: light sender idling, heavy idling, then none.
    idle_pct = 24;
    random_run(300);
    set_all(24'h800000, 24'hffffff, 24'h7fffff, 24'h000001);
    random_run(150);
    idle_pct = 69;
    set_all(24'h7fffff, 24'h000001, 24'h800000, 24'hffffff);
    random_run(150);
    set_all(24'd0, 24'd1000000, 24'd0, 24'd100000);
    random_run(200);
    idle_pct = 0;
    set_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    random_run(150);
    set_all(24'd18595, 24'd394525, 24'd120260, 24'd55901);
    random_run(375);
    start <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("bivariate_polynomial_current_predictor_tb: done, clean");
    end else begin
      $display("bivariate_polynomial_current_predictor_tb: done, errors");
    end
    $finish;
  end
endmodule
